### hdl/triangle_tangent_binormal_assert.svh
// Assertion macros for the triangle tangent and binormal unit.
// Used by modules that check their own control sequencing; expects clk and arst_n in scope.
`ifndef TRIANGLE_TANGENT_BINORMAL_ASSERT_SVH
`define TRIANGLE_TANGENT_BINORMAL_ASSERT_SVH
`ifndef SYNTHESIS
`define TTB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ttb assertion failed");
`define TTB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttb assertion failed");
`else
`define TTB_ASSERT(lbl, prop)
`define TTB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/ttb_pkg.sv
// Shared types and helpers for the triangle tangent and binormal unit.
// No dependencies; used by ttb_ctrl, ttb_dp and the top level.
`default_nettype none
package ttb_pkg;

	localparam int DW    = 32;   // input field width
	localparam int OW    = 16;   // output vector field width
	localparam int RW    = 65;   // product difference width
	localparam int MW    = 64;   // component magnitude width
	localparam int SW    = 62;   // sum of squares width
	localparam int LW    = 31;   // length width
	localparam int NW    = 46;   // divider numerator width
	localparam int QW    = 15;   // quotient width
	localparam int NPROD = 14;   // products for determinant, T and B
	localparam int NSQRT = 31;   // square root iterations

	typedef struct packed {
		logic [DW-1:0] x;
		logic [DW-1:0] y;
		logic [DW-1:0] z;
		logic [DW-1:0] u;
		logic [DW-1:0] v;
	} vtx_t;

	typedef struct packed {
		logic       load_v0;
		logic       load_v1;
		logic       load_dlt;
		logic       mul_go;
		logic       mul_acc;
		logic [3:0] step;
		logic       nload;
		logic       vsel;
		logic       shift;
		logic       sqrt_init;
		logic       sqrt_iter;
		logic       div_init;
		logic       div_iter;
		logic       div_last;
		logic       out_load;
		logic       degen;
	} cmd_t;

	typedef struct packed {
		logic det_zero;
		logic mag_zero;
		logic mag_big;
	} sts_t;

	// difference of two signed words, halved toward zero
	function automatic logic signed [DW-1:0] half_diff(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		logic signed [DW:0] d;
		d = {a[DW-1], a} - {b[DW-1], b};
		d = d + {{DW{1'b0}}, d[DW]};
		return d[DW:1];
	endfunction

endpackage
`default_nettype wire

### hdl/ttb_dp.sv
// Datapath: held vertices, shared multiplier, normaliser, square root and divider.
// Depends on ttb_pkg; driven by commands from ttb_ctrl.
`default_nettype none
module ttb_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ttb_pkg::cmd_t      cmd,
	input  wire ttb_pkg::vtx_t      cur,
	output ttb_pkg::sts_t           sts,
	output logic signed [15:0]      tan_x,
	output logic signed [15:0]      tan_y,
	output logic signed [15:0]      tan_z,
	output logic signed [15:0]      bin_x,
	output logic signed [15:0]      bin_y,
	output logic signed [15:0]      bin_z,
	output logic                    degenerate
);

	ttb_pkg::vtx_t v0_q, v1_q;

	logic signed [ttb_pkg::DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [ttb_pkg::DW-1:0] e1_q [3];
	logic signed [ttb_pkg::DW-1:0] e2_q [3];

	logic signed [ttb_pkg::DW-1:0] op_a, op_b;
	logic signed [63:0]            prod_s1;
	logic                          pvalid_s1, pacc_s1;
	logic [3:0]                    pidx_s1;
	logic signed [63:0]            first_q;
	logic signed [ttb_pkg::RW-1:0] res_q [7];

	logic [ttb_pkg::MW-1:0] mag_q [3];
	logic [2:0]             neg_q;
	logic [ttb_pkg::SW-1:0] sum_q;
	logic [ttb_pkg::SW-1:0] x_q, r_q, bit_q, sq_t;
	logic [ttb_pkg::NW-1:0] num_q, dvs_q;
	logic [ttb_pkg::QW-1:0] q_q, q_fin;
	logic                   ge;
	logic signed [ttb_pkg::OW-1:0] outw_q [6];
	logic signed [ttb_pkg::OW-1:0] val16;
	logic [ttb_pkg::LW-1:0] len;
	logic                   big8;

	assign sts.det_zero = (res_q[0] == '0);
	assign sts.mag_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
	assign sts.mag_big  = (|mag_q[0][63:30]) || (|mag_q[1][63:30]) || (|mag_q[2][63:30]);
	assign big8 = (|mag_q[0][63:38]) || (|mag_q[1][63:38]) || (|mag_q[2][63:38]);

	assign len   = r_q[ttb_pkg::LW-1:0];
	assign sq_t  = r_q + bit_q;
	assign ge    = (num_q >= dvs_q);
	assign q_fin = {q_q[ttb_pkg::QW-2:0], ge};
	assign val16 = neg_q[0] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});

	// operand selection for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (cmd.mul_acc) begin
			case (cmd.step)
				4'd0: begin op_a = $signed(mag_q[0][31:0]); op_b = $signed(mag_q[0][31:0]); end
				4'd1: begin op_a = $signed(mag_q[1][31:0]); op_b = $signed(mag_q[1][31:0]); end
				4'd2: begin op_a = $signed(mag_q[2][31:0]); op_b = $signed(mag_q[2][31:0]); end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end else begin
			case (cmd.step)
				4'd0:  begin op_a = du1_q; op_b = dv2_q;   end
				4'd1:  begin op_a = du2_q; op_b = dv1_q;   end
				4'd2:  begin op_a = dv2_q; op_b = e1_q[0]; end
				4'd3:  begin op_a = dv1_q; op_b = e2_q[0]; end
				4'd4:  begin op_a = dv2_q; op_b = e1_q[1]; end
				4'd5:  begin op_a = dv1_q; op_b = e2_q[1]; end
				4'd6:  begin op_a = dv2_q; op_b = e1_q[2]; end
				4'd7:  begin op_a = dv1_q; op_b = e2_q[2]; end
				4'd8:  begin op_a = du1_q; op_b = e2_q[0]; end
				4'd9:  begin op_a = du2_q; op_b = e1_q[0]; end
				4'd10: begin op_a = du1_q; op_b = e2_q[1]; end
				4'd11: begin op_a = du2_q; op_b = e1_q[1]; end
				4'd12: begin op_a = du1_q; op_b = e2_q[2]; end
				4'd13: begin op_a = du2_q; op_b = e1_q[2]; end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_s1 <= 1'b0;
		end else begin
			pvalid_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_v0) v0_q <= cur;
		if (cmd.load_v1) v1_q <= cur;
		if (cmd.load_dlt) begin
			e1_q[0] <= ttb_pkg::half_diff(v1_q.x, v0_q.x);
			e1_q[1] <= ttb_pkg::half_diff(v1_q.y, v0_q.y);
			e1_q[2] <= ttb_pkg::half_diff(v1_q.z, v0_q.z);
			e2_q[0] <= ttb_pkg::half_diff(cur.x, v0_q.x);
			e2_q[1] <= ttb_pkg::half_diff(cur.y, v0_q.y);
			e2_q[2] <= ttb_pkg::half_diff(cur.z, v0_q.z);
			du1_q   <= ttb_pkg::half_diff(v1_q.u, v0_q.u);
			dv1_q   <= ttb_pkg::half_diff(v1_q.v, v0_q.v);
			du2_q   <= ttb_pkg::half_diff(cur.u, v0_q.u);
			dv2_q   <= ttb_pkg::half_diff(cur.v, v0_q.v);
		end

		prod_s1 <= op_a * op_b;
		pacc_s1 <= cmd.mul_acc;
		pidx_s1 <= cmd.step;

		// pair products: keep the first, subtract the second
		if (pvalid_s1 && !pacc_s1) begin
			if (!pidx_s1[0]) begin
				first_q <= prod_s1;
			end else begin
				res_q[pidx_s1[3:1]] <= {first_q[63], first_q} - {prod_s1[63], prod_s1};
			end
		end

		if (cmd.nload) begin
			sum_q <= '0;
			for (int i = 0; i < 3; i++) begin
				logic signed [ttb_pkg::RW-1:0] v;
				v = cmd.vsel ? res_q[4+i] : res_q[1+i];
				neg_q[i] <= v[ttb_pkg::RW-1] ^ res_q[0][ttb_pkg::RW-1];
				mag_q[i] <= v[ttb_pkg::RW-1] ? ttb_pkg::MW'(-v) : ttb_pkg::MW'(v);
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= big8 ? (mag_q[i] >> 8) : (mag_q[i] >> 1);
			end
		end else if (cmd.div_iter && cmd.div_last) begin
			// rotate so the next component sits in slot 0
			mag_q[0] <= mag_q[1];
			mag_q[1] <= mag_q[2];
			mag_q[2] <= mag_q[0];
			neg_q    <= {neg_q[0], neg_q[2:1]};
		end

		if (pvalid_s1 && pacc_s1) begin
			sum_q <= sum_q + prod_s1[ttb_pkg::SW-1:0];
		end

		if (cmd.sqrt_init) begin
			x_q   <= sum_q;
			r_q   <= '0;
			bit_q <= ttb_pkg::SW'(1) << 60;
		end else if (cmd.sqrt_iter) begin
			if (x_q >= sq_t) begin
				x_q <= x_q - sq_t;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.div_init) begin
			num_q <= {2'b00, mag_q[0][29:0], 14'd0} + {15'd0, 1'b0, len[ttb_pkg::LW-1:1]};
			dvs_q <= {1'b0, len, 14'd0};
			q_q   <= '0;
		end else if (cmd.div_iter) begin
			if (ge) num_q <= num_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			q_q   <= q_fin;
			if (cmd.div_last) begin
				for (int i = 0; i < 5; i++) outw_q[i] <= outw_q[i+1];
				outw_q[5] <= val16;
			end
		end

		if (cmd.out_load) begin
			tan_x      <= cmd.degen ? '0 : outw_q[0];
			tan_y      <= cmd.degen ? '0 : outw_q[1];
			tan_z      <= cmd.degen ? '0 : outw_q[2];
			bin_x      <= cmd.degen ? '0 : outw_q[3];
			bin_y      <= cmd.degen ? '0 : outw_q[4];
			bin_z      <= cmd.degen ? '0 : outw_q[5];
			degenerate <= cmd.degen;
		end
	end

endmodule
`default_nettype wire

### hdl/ttb_ctrl.sv
// Controller: triangle phase, handshakes and the per-triangle command sequence.
// Depends on ttb_pkg and the assertion macro header.
`default_nettype none
`include "triangle_tangent_binormal_assert.svh"
module ttb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          last_vertex,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire ttb_pkg::sts_t sts,
	output ttb_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL    = 4'd1;
	localparam logic [3:0] S_DETCHK = 4'd2;
	localparam logic [3:0] S_NLOAD  = 4'd3;
	localparam logic [3:0] S_NSHIFT = 4'd4;
	localparam logic [3:0] S_SQ     = 4'd5;
	localparam logic [3:0] S_SQI    = 4'd6;
	localparam logic [3:0] S_SQRT   = 4'd7;
	localparam logic [3:0] S_DINIT  = 4'd8;
	localparam logic [3:0] S_DIV    = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0] state_q;
	logic [1:0] phase_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic       sel_q, degen_q, out_valid_q;
	logic       acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.load_v0   = acc && ((phase_q == 2'd0) || (phase_q == 2'd3));
		cmd.load_v1   = acc && (phase_q == 2'd1);
		cmd.load_dlt  = acc && (phase_q == 2'd2);
		cmd.step      = cnt_q[3:0];
		cmd.vsel      = sel_q;
		cmd.degen     = degen_q;
		case (state_q)
			S_MUL:    cmd.mul_go = (cnt_q < 5'(ttb_pkg::NPROD));
			S_NLOAD:  cmd.nload = 1'b1;
			S_NSHIFT: cmd.shift = !sts.mag_zero && sts.mag_big;
			S_SQ: begin
				cmd.mul_go  = (cnt_q < 5'd3);
				cmd.mul_acc = 1'b1;
			end
			S_SQI:    cmd.sqrt_init = 1'b1;
			S_SQRT:   cmd.sqrt_iter = 1'b1;
			S_DINIT:  cmd.div_init = 1'b1;
			S_DIV: begin
				cmd.div_iter = 1'b1;
				cmd.div_last = (cnt_q == 5'(ttb_pkg::QW - 1));
			end
			S_OUT:    cmd.out_load = !out_valid_q;
			default:  cmd.mul_go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 2'd0;
			cnt_q       <= '0;
			comp_q      <= '0;
			sel_q       <= 1'b0;
			degen_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			if (acc) begin
				if (last_vertex || (phase_q == 2'd2)) begin
					phase_q <= 2'd0;
				end else if (phase_q == 2'd3) begin
					phase_q <= 2'd1;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.load_dlt) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
						degen_q <= 1'b0;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ttb_pkg::NPROD)) state_q <= S_DETCHK;
				end
				S_DETCHK: begin
					sel_q <= 1'b0;
					if (sts.det_zero) begin
						degen_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_NLOAD;
					end
				end
				S_NLOAD: state_q <= S_NSHIFT;
				S_NSHIFT: begin
					cnt_q <= '0;
					if (sts.mag_zero) begin
						degen_q <= 1'b1;
						state_q <= S_OUT;
					end else if (!sts.mag_big) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) state_q <= S_SQI;
				end
				S_SQI: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ttb_pkg::NSQRT - 1)) begin
						comp_q  <= '0;
						state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cmd.div_last) begin
						if (comp_q == 2'd2) begin
							if (!sel_q) begin
								sel_q   <= 1'b1;
								state_q <= S_NLOAD;
							end else begin
								state_q <= S_OUT;
							end
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_DINIT;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TTB_ASSERT_NEXT(a_third_vertex_starts, acc && (phase_q == 2'd2), state_q == S_MUL)
	`TTB_ASSERT_NEXT(a_result_loads, (state_q == S_OUT) && !out_valid_q, out_valid_q && in_ready)
	`TTB_ASSERT(a_phase_legal, phase_q != 2'd3)
	`TTB_ASSERT(a_comp_range, (state_q != S_DIV) || (comp_q != 2'd3))

endmodule
`default_nettype wire

### hdl/triangle_tangent_binormal.sv
// Per-triangle tangent/binormal unit. First two vertices of a triangle are only registered.
// The third vertex starts the computation (cut short on a zero determinant), done by the
// shift normaliser, the bit-per-cycle square root (once per vector) and the restoring
// divider (once per component). Input is taken again in the same cycle as the result.
// A held result stalls only the next triangle's finish; its first two vertices are taken.
// Reset (arst_n low, asynchronous) clears triangle phase, sequencer and output valid.
`default_nettype none
module triangle_tangent_binormal (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] tex_u,
	input  wire logic signed [31:0] tex_v,
	input  wire logic               last_vertex,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      tan_x,
	output logic signed [15:0]      tan_y,
	output logic signed [15:0]      tan_z,
	output logic signed [15:0]      bin_x,
	output logic signed [15:0]      bin_y,
	output logic signed [15:0]      bin_z,
	output logic                    degenerate
);

	ttb_pkg::cmd_t cmd;
	ttb_pkg::sts_t sts;
	ttb_pkg::vtx_t cur;

	assign cur.x = pos_x;
	assign cur.y = pos_y;
	assign cur.z = pos_z;
	assign cur.u = tex_u;
	assign cur.v = tex_v;

	ttb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	ttb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cur        (cur),
		.sts        (sts),
		.tan_x      (tan_x),
		.tan_y      (tan_y),
		.tan_z      (tan_z),
		.bin_x      (bin_x),
		.bin_y      (bin_y),
		.bin_z      (bin_z),
		.degenerate (degenerate)
	);

endmodule
`default_nettype wire
